// ===== hdl/motor_drive_level_regulator_macros.svh =====
// Assertion macros used by the checker of the drive level regulator.
`ifndef MOTOR_DRIVE_LEVEL_REGULATOR_MACROS_SVH
`define MOTOR_DRIVE_LEVEL_REGULATOR_MACROS_SVH

// Implication checked out of reset.
`define MDLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdlr check failed");

// Next-cycle implication checked out of reset.
`define MDLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdlr check failed");

// Next-cycle implication that also holds through reset.
`define MDLR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mdlr reset check failed");

`endif

// ===== hdl/mdlr_pkg.sv =====
// Package with field widths, codes and types of the drive level regulator.
`timescale 1ns / 1ps
package mdlr_pkg;

  localparam int TargetW   = 14;
  localparam int BrakeW    = 12;
  localparam int CurrentW  = 13;
  localparam int SpeedW    = 14;
  localparam int HallW     = 9;
  localparam int DriveW    = 11;
  localparam int AdvanceW  = 6;
  localparam int ModeW     = 2;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 14;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 24;
  localparam int CalcW     = 15;

  localparam int PwmMidDefault = 0;
  localparam int PwmMaxDefault = 1000;

  localparam logic [ModeW-1:0] MODE_DUTY    = 2'd0;
  localparam logic [ModeW-1:0] MODE_CURRENT = 2'd1;
  localparam logic [ModeW-1:0] MODE_SPEED   = 2'd2;

  localparam logic [CfgIndexW-1:0] REG_CONTROL_MODE       = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_CURRENT_LIMIT      = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_BRAKE_BY_CURRENT   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_COAST_ENABLE       = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_WEAKEN_ENABLE      = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_WEAKEN_SPEED       = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_WEAKEN_CURRENT     = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_WEAKEN_MAX_ADVANCE = 3'd7;

  typedef struct packed {
    logic                       weaken_slot;
    logic [HallW-1:0]           hall_angle;
    logic [SpeedW-1:0]          rotor_speed;
    logic signed [CurrentW-1:0] motor_current;
    logic [BrakeW-1:0]          brake_level;
    logic [TargetW-1:0]         target_level;
  } in_item_t;

endpackage

// ===== hdl/motor_drive_level_regulator.sv =====
// Top level of the motor drive level regulator.
`timescale 1ns / 1ps
// One item per control tick moves the stored drive level by single steps, or sets it to the
// saturated target or to zero, in one of three regulation modes (duty, current, speed) and
// steps the field weakening advance on flagged slots. An accepted item is held in the input
// register, then the step logic writes the result register, which is also the stored drive
// level and advance and offers the result. A new item is taken every cycle while results are
// taken; a held result stalls the input register and with it in_tready. cfg_ready is always
// high; write registers only while no item is in flight. PWM_MID and PWM_MAX bound the drive
// level; the user must keep them within -1000..1000 and 1..1000; the block does not enforce it.
module motor_drive_level_regulator #(
  parameter int PWM_MID = mdlr_pkg::PwmMidDefault,
  parameter int PWM_MAX = mdlr_pkg::PwmMaxDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // target_level[13:0], brake_level[25:14], motor_current[38:26], rotor_speed[52:39],
  // hall_angle[61:53], weaken_slot[62], zero[63]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mdlr_pkg::InDataW-1:0]   in_tdata,
  // drive_level[10:0], weaken_advance[16:11], zero[23:17]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mdlr_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mdlr_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mdlr_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int W = mdlr_pkg::CalcW;
  localparam logic signed [W-1:0] PwmMid = W'(PWM_MID);
  localparam logic signed [W-1:0] PwmMax = W'(PWM_MAX);
  localparam logic signed [W-1:0] Zero   = '0;

  logic [mdlr_pkg::ModeW-1:0]            mode_r;
  logic [mdlr_pkg::BrakeW-1:0]           lim_r;
  logic                                  bbc_r;
  logic                                  coast_r;
  logic                                  wen_r;
  logic [mdlr_pkg::SpeedW-1:0]           wspd_r;
  logic signed [mdlr_pkg::CurrentW-1:0]  wcur_r;
  logic [mdlr_pkg::AdvanceW-1:0]         wmax_r;

  mdlr_pkg::in_item_t                    s1_r;
  logic                                  s1_valid_r;
  logic                                  s1_adv;

  logic signed [mdlr_pkg::DriveW-1:0]    drive_r, drive_nxt;
  logic [mdlr_pkg::AdvanceW-1:0]         adv_r, adv_nxt;
  logic [mdlr_pkg::HallW-1:0]            hall_r;
  logic                                  out_valid_r;

  function automatic logic signed [W-1:0] dec_above(logic signed [W-1:0] d,
                                                    logic signed [W-1:0] fl);
    return (d > fl) ? d - W'(1) : d;
  endfunction

  function automatic logic signed [W-1:0] inc_below(logic signed [W-1:0] d);
    return (d < PwmMax) ? d + W'(1) : d;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mdlr_pkg::MODE_DUTY;
      lim_r   <= '0;
      bbc_r   <= 1'b0;
      coast_r <= 1'b0;
      wen_r   <= 1'b0;
      wspd_r  <= '0;
      wcur_r  <= '0;
      wmax_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mdlr_pkg::REG_CONTROL_MODE:       mode_r  <= cfg_data[mdlr_pkg::ModeW-1:0];
        mdlr_pkg::REG_CURRENT_LIMIT:      lim_r   <= cfg_data[mdlr_pkg::BrakeW-1:0];
        mdlr_pkg::REG_BRAKE_BY_CURRENT:   bbc_r   <= cfg_data[0];
        mdlr_pkg::REG_COAST_ENABLE:       coast_r <= cfg_data[0];
        mdlr_pkg::REG_WEAKEN_ENABLE:      wen_r   <= cfg_data[0];
        mdlr_pkg::REG_WEAKEN_SPEED:       wspd_r  <= cfg_data[mdlr_pkg::SpeedW-1:0];
        mdlr_pkg::REG_WEAKEN_CURRENT:     wcur_r  <= $signed(cfg_data[mdlr_pkg::CurrentW-1:0]);
        mdlr_pkg::REG_WEAKEN_MAX_ADVANCE: wmax_r  <= cfg_data[mdlr_pkg::AdvanceW-1:0];
        default: ;
      endcase
    end
  end

  // advance the input register whenever the result register is free or being taken
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r <= mdlr_pkg::in_item_t'(in_tdata[$bits(mdlr_pkg::in_item_t)-1:0]);
    end
  end

  always_comb begin
    logic signed [W-1:0] d;
    logic signed [W-1:0] tgt;
    logic signed [W-1:0] brk;
    logic signed [W-1:0] nbrk;
    logic signed [W-1:0] cur;
    logic signed [W-1:0] spd;
    logic signed [W-1:0] lim;
    logic                edge_seen;
    logic                brk_on;
    logic                lim_on;
    logic                wrise;
    d         = W'(drive_r);
    tgt       = W'(s1_r.target_level);
    brk       = W'(s1_r.brake_level);
    nbrk      = -brk;
    cur       = W'(s1_r.motor_current);
    spd       = W'(s1_r.rotor_speed);
    lim       = W'(lim_r);
    edge_seen = (hall_r != s1_r.hall_angle);
    brk_on    = (brk != Zero);
    lim_on    = (lim_r != '0);

    case (mode_r)
      mdlr_pkg::MODE_DUTY: begin
        if (!lim_on) begin
          d = (tgt > PwmMax) ? PwmMax : tgt;
        end else begin
          if (brk_on) begin
            if (bbc_r) begin
              d = (cur > nbrk) ? dec_above(d, Zero) : inc_below(d);
            end else if (d > tgt) begin
              d = d - W'(1);
            end
          end
          if (tgt > Zero && !brk_on) begin
            if (cur < lim) begin
              if (tgt > d) begin
                if (d < PwmMax && d < tgt) d = d + W'(1);
              end else if (cur < Zero) begin
                if (d > tgt) d = d - W'(1);
              end
            end
            if (cur > lim) d = dec_above(d, PwmMid);
          end
          if (!brk_on) begin
            if (coast_r) begin
              if (tgt == Zero && cur > Zero) d = dec_above(d, PwmMid);
              if (tgt == Zero && cur <= Zero && edge_seen) d = inc_below(d);
            end else if (tgt < d) begin
              d = dec_above(d, PwmMid);
            end
          end
        end
      end
      mdlr_pkg::MODE_CURRENT: begin
        if (!lim_on) begin
          d = Zero;
        end else begin
          if (brk_on && spd > Zero) begin
            if (!bbc_r || cur > nbrk) d = dec_above(d, PwmMid);
          end else if (d < Zero) begin
            d = Zero;
          end
          if (tgt > Zero && !brk_on) begin
            if (cur < tgt) d = inc_below(d);
            if (cur > tgt) d = dec_above(d, PwmMid);
          end
          if (!brk_on) begin
            if (coast_r) begin
              if (tgt == Zero && cur > Zero) d = dec_above(d, PwmMid);
              if (tgt == Zero && cur <= Zero && edge_seen) d = inc_below(d);
            end else begin
              d = dec_above(d, PwmMid);
            end
          end
        end
      end
      mdlr_pkg::MODE_SPEED: begin
        if (!lim_on) begin
          d = Zero;
        end else begin
          if (brk_on) begin
            if (bbc_r) begin
              d = (cur > nbrk) ? dec_above(d, Zero) : inc_below(d);
            end else if (spd > tgt) begin
              d = dec_above(d, PwmMid);
            end
          end
          if (tgt > Zero && !brk_on) begin
            if (cur < lim) begin
              if (tgt > spd) d = inc_below(d);
              else if (cur < Zero) d = dec_above(d, PwmMid);
            end
            if (cur > lim) d = dec_above(d, PwmMid);
          end
          if (!brk_on) begin
            if (coast_r) begin
              if (tgt == Zero && cur > Zero) d = dec_above(d, PwmMid);
              if (tgt == Zero && cur <= Zero && edge_seen) d = inc_below(d);
            end else if (tgt < d) begin
              d = dec_above(d, PwmMid);
            end
          end
        end
      end
      default: ;
    endcase
    drive_nxt = d[mdlr_pkg::DriveW-1:0];

    adv_nxt = adv_r;
    wrise   = (s1_r.rotor_speed >= wspd_r) && (tgt > Zero) && !brk_on;
    if (wen_r && lim_on && s1_r.weaken_slot) begin
      if (wrise && s1_r.motor_current < wcur_r) begin
        if (adv_r < wmax_r) adv_nxt = adv_r + 1'b1;
      end else if (adv_r != '0) begin
        adv_nxt = adv_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r     <= '0;
      adv_r       <= '0;
      hall_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        drive_r <= drive_nxt;
        adv_r   <= adv_nxt;
        hall_r  <= s1_r.hall_angle;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mdlr_pkg::OutDataW - mdlr_pkg::DriveW - mdlr_pkg::AdvanceW){1'b0}},
                       adv_r, drive_r};

endmodule

// ===== hdl/mdlr_checker.sv =====
// Port-level checker of the drive level regulator and its bind.
`timescale 1ns / 1ps
`include "motor_drive_level_regulator_macros.svh"
module mdlr_checker #(
  parameter int PWM_MID = mdlr_pkg::PwmMidDefault,
  parameter int PWM_MAX = mdlr_pkg::PwmMaxDefault
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mdlr_pkg::OutDataW-1:0]  out_tdata
);

  localparam int W = mdlr_pkg::CalcW;
  localparam logic signed [W-1:0] Lo = (PWM_MID < 0) ? W'(PWM_MID) : '0;
  localparam logic signed [W-1:0] Hi = W'(PWM_MAX);

  logic signed [W-1:0] drive_w;
  assign drive_w = W'($signed(out_tdata[mdlr_pkg::DriveW-1:0]));

  `MDLR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MDLR_ASSERT_IMP(a_stall_only_on_held, !in_tready, out_tvalid && !out_tready)
  `MDLR_ASSERT_IMP(a_drive_range, out_tvalid, drive_w >= Lo && drive_w <= Hi)
  `MDLR_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid && in_tready)

endmodule

bind motor_drive_level_regulator mdlr_checker #(
  .PWM_MID(PWM_MID),
  .PWM_MAX(PWM_MAX)
) u_mdlr_checker (.*);

// ===== tb/motor_drive_level_regulator_tb.sv =====
// Testbench for the drive level regulator: directed and random ticks under many settings.
`timescale 1ns / 1ps
module motor_drive_level_regulator_tb;

  localparam int PwmMid = mdlr_pkg::PwmMidDefault;
  localparam int PwmMax = mdlr_pkg::PwmMaxDefault;
  localparam logic [mdlr_pkg::ModeW-1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic signed [mdlr_pkg::DriveW-1:0] drive;
    logic [mdlr_pkg::AdvanceW-1:0]      adv;
  } level_t;

  typedef struct {
    int mode, lim, bbc, coast, wen, wspd, wcur, wmax, count, grow;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [mdlr_pkg::InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mdlr_pkg::OutDataW-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mdlr_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [mdlr_pkg::CfgDataW-1:0] cfg_data = '0;

  motor_drive_level_regulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // register copy and stored state
  logic [mdlr_pkg::ModeW-1:0] cfg_mode = mdlr_pkg::MODE_DUTY;
  int cfg_lim = 0, cfg_bbc = 0, cfg_coast = 0, cfg_wen = 0;
  int cfg_wspd = 0, cfg_wcur = 0, cfg_wmax = 0;
  int lvl = 0, adv = 0, hall_seen = 0;

  mdlr_pkg::in_item_t tick_q[$];
  level_t level_q[$];
  int gen_hall = 0;
  int items_taken = 0, results_seen = 0, mismatches = 0;
  logic calm = 1'b0;

  function automatic void lvl_down(input int floor_v);
    if (lvl > floor_v) lvl--;
  endfunction

  function automatic void lvl_up();
    if (lvl < PwmMax) lvl++;
  endfunction

  function automatic void coast_step(input int tgt, input int cur, input bit hall_moved,
                                     input bit release_cmp);
    if (cfg_coast != 0) begin
      if (tgt == 0 && cur > 0) lvl_down(PwmMid);
      if (tgt == 0 && cur <= 0 && hall_moved) lvl_up();
    end else if (release_cmp) begin
      if (tgt < lvl) lvl_down(PwmMid);
    end else begin
      lvl_down(PwmMid);
    end
  endfunction

  function automatic level_t regulate_tick(input mdlr_pkg::in_item_t it);
    int tgt, brk, cur, spd;
    bit hall_moved, slot;
    level_t r;
    tgt = it.target_level;
    brk = it.brake_level;
    cur = it.motor_current;
    spd = it.rotor_speed;
    slot = it.weaken_slot;
    hall_moved = (hall_seen != it.hall_angle);
    if (hall_moved) hall_seen = it.hall_angle;
    case (cfg_mode)
      mdlr_pkg::MODE_DUTY: begin
        if (cfg_lim == 0) begin
          lvl = (tgt > PwmMax) ? PwmMax : tgt;
        end else begin
          if (brk > 0) begin
            if (cfg_bbc != 0) begin
              if (cur > -brk) lvl_down(0);
              else lvl_up();
            end else if (lvl > tgt) begin
              lvl--;
            end
          end
          if (tgt > 0 && brk == 0) begin
            if (cur < cfg_lim) begin
              if (tgt > lvl) begin
                if (lvl < PwmMax && lvl < tgt) lvl++;
              end else if (cur < 0) begin
                if (lvl > tgt) lvl--;
              end
            end
            if (cur > cfg_lim) lvl_down(PwmMid);
          end
          if (brk == 0) coast_step(tgt, cur, hall_moved, 1'b1);
        end
      end
      mdlr_pkg::MODE_CURRENT: begin
        if (cfg_lim == 0) begin
          lvl = 0;
        end else begin
          if (brk > 0 && spd > 0) begin
            if (cfg_bbc != 0) begin
              if (cur > -brk) lvl_down(PwmMid);
            end else begin
              lvl_down(PwmMid);
            end
          end else if (lvl < 0) begin
            lvl = 0;
          end
          if (tgt > 0 && brk == 0) begin
            if (cur < tgt) lvl_up();
            if (cur > tgt) lvl_down(PwmMid);
          end
          if (brk == 0) coast_step(tgt, cur, hall_moved, 1'b0);
        end
      end
      mdlr_pkg::MODE_SPEED: begin
        if (cfg_lim == 0) begin
          lvl = 0;
        end else begin
          if (brk > 0) begin
            if (cfg_bbc != 0) begin
              if (cur > -brk) lvl_down(0);
              else lvl_up();
            end else if (spd > tgt) begin
              lvl_down(PwmMid);
            end
          end
          if (tgt > 0 && brk == 0) begin
            if (cur < cfg_lim) begin
              if (tgt > spd) lvl_up();
              else if (cur < 0) lvl_down(PwmMid);
            end
            if (cur > cfg_lim) lvl_down(PwmMid);
          end
          if (brk == 0) coast_step(tgt, cur, hall_moved, 1'b1);
        end
      end
      default: ;
    endcase
    if (cfg_wen != 0 && cfg_lim > 0 && slot) begin
      if (spd >= cfg_wspd && tgt > 0 && brk == 0) begin
        if (cur < cfg_wcur) begin
          if (adv < cfg_wmax) adv++;
        end else if (adv > 0) begin
          adv--;
        end
      end else if (adv > 0) begin
        adv--;
      end
    end
    adv = adv & 63;
    r.drive = mdlr_pkg::DriveW'(lvl);
    r.adv = mdlr_pkg::AdvanceW'(adv);
    return r;
  endfunction

  function automatic void apply_reg(input logic [mdlr_pkg::CfgIndexW-1:0] idx, input int val);
    case (idx)
      mdlr_pkg::REG_CONTROL_MODE:       cfg_mode = mdlr_pkg::ModeW'(val);
      mdlr_pkg::REG_CURRENT_LIMIT:      cfg_lim = val & 12'hFFF;
      mdlr_pkg::REG_BRAKE_BY_CURRENT:   cfg_bbc = val & 1;
      mdlr_pkg::REG_COAST_ENABLE:       cfg_coast = val & 1;
      mdlr_pkg::REG_WEAKEN_ENABLE:      cfg_wen = val & 1;
      mdlr_pkg::REG_WEAKEN_SPEED:       cfg_wspd = val & 14'h3FFF;
      mdlr_pkg::REG_WEAKEN_CURRENT:     cfg_wcur = $signed(13'(val));
      mdlr_pkg::REG_WEAKEN_MAX_ADVANCE: cfg_wmax = val & 6'h3F;
      default: ;
    endcase
  endfunction

  function automatic mdlr_pkg::in_item_t tick_of(input int tgt, input int brk, input int cur,
                                                 input int spd, input int hall,
                                                 input int slot);
    mdlr_pkg::in_item_t it;
    it.target_level = mdlr_pkg::TargetW'(tgt);
    it.brake_level = mdlr_pkg::BrakeW'(brk);
    it.motor_current = mdlr_pkg::CurrentW'(cur);
    it.rotor_speed = mdlr_pkg::SpeedW'(spd);
    it.hall_angle = mdlr_pkg::HallW'(hall);
    it.weaken_slot = slot[0];
    return it;
  endfunction

  function automatic mdlr_pkg::in_item_t make_tick(input phase_t p);
    int r, tgt, brk, cur, spd;
    bit slot;
    r = $urandom_range(0, 9);
    if (r < 2 && p.grow == 0) tgt = 0;
    else if (r == 2) tgt = 16383;
    else if (r < 7) tgt = $urandom_range(1, 1100);
    else tgt = $urandom_range(1, 16383);
    r = $urandom_range(0, 9);
    if (r < ((p.grow != 0) ? 9 : 6)) brk = 0;
    else if (r == 9) brk = 4095;
    else brk = $urandom_range(1, 4094);
    r = $urandom_range(0, 9);
    if (p.grow != 0 && r < 8) cur = -4096 + int'($urandom_range(0, p.wcur + 4095));
    else if (r == 0) cur = -4096;
    else if (r == 1) cur = 4095;
    else if (r < 5) cur = p.lim - 3 + int'($urandom_range(0, 6));
    else if (r < 7 && brk > 0) cur = -brk - 2 + int'($urandom_range(0, 4));
    else if (r < 8) cur = -40 + int'($urandom_range(0, 80));
    else cur = -4096 + int'($urandom_range(0, 8191));
    if (cur > 4095) cur = 4095;
    if (cur < -4096) cur = -4096;
    r = $urandom_range(0, 9);
    if (p.grow != 0 && r < 8) spd = p.wspd + int'($urandom_range(0, 16383 - p.wspd));
    else if (r == 0) spd = 0;
    else if (r == 1) spd = 16383;
    else if (r < 5) spd = tgt - 2 + int'($urandom_range(0, 4));
    else if (r < 7) spd = p.wspd - 1 + int'($urandom_range(0, 2));
    else spd = $urandom_range(0, 16383);
    if (spd > 16383) spd = 16383;
    if (spd < 0) spd = 0;
    if ($urandom_range(0, 3) == 0) gen_hall = $urandom_range(0, 360);
    slot = (p.grow != 0) ? ($urandom_range(0, 9) != 0) : $urandom_range(0, 1);
    return tick_of(tgt, brk, cur, spd, gen_hall, slot);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        in_tdata <= {1'b0, tick_q.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predict on input, check on output, drive out_tready
  int hold_cnt = 0;
  bit stall_done = 1'b0;

  always @(posedge clk) begin : monitor
    level_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        level_q.push_back(regulate_tick(
            mdlr_pkg::in_item_t'(in_tdata[mdlr_pkg::InDataW-2:0])));
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        got.drive = out_tdata[mdlr_pkg::DriveW-1:0];
        got.adv = out_tdata[mdlr_pkg::DriveW+mdlr_pkg::AdvanceW-1:mdlr_pkg::DriveW];
        results_seen++;
        if (level_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no item pending: drive %0d advance %0d",
                     results_seen, got.drive, got.adv);
        end else begin
          want = level_q.pop_front();
          if (got.drive !== want.drive || got.adv !== want.adv) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: drive %0d advance %0d, expected drive %0d advance %0d",
                       results_seen, got.drive, got.adv, want.drive, want.adv);
          end
        end
      end
      if (results_seen == 150 && !stall_done) begin
        hold_cnt = 400;
        stall_done = 1'b1;
      end
      if (hold_cnt > 0) hold_cnt--;
      out_tready <= (hold_cnt == 0) && (calm || $urandom_range(0, 99) >= 6);
      calm <= (items_taken >= 400 && items_taken < 520);
    end
  end

  task automatic program_regs(input phase_t p);
    logic [mdlr_pkg::CfgIndexW-1:0] idx [8];
    int val [8];
    idx = '{mdlr_pkg::REG_CONTROL_MODE, mdlr_pkg::REG_CURRENT_LIMIT,
            mdlr_pkg::REG_BRAKE_BY_CURRENT, mdlr_pkg::REG_COAST_ENABLE,
            mdlr_pkg::REG_WEAKEN_ENABLE, mdlr_pkg::REG_WEAKEN_SPEED,
            mdlr_pkg::REG_WEAKEN_CURRENT, mdlr_pkg::REG_WEAKEN_MAX_ADVANCE};
    val = '{p.mode, p.lim, p.bbc, p.coast, p.wen, p.wspd, p.wcur, p.wmax};
    @(posedge clk);
    for (int k = 0; k < 8; k++) begin
      cfg_index <= idx[k];
      cfg_data <= mdlr_pkg::CfgDataW'(val[k]);
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || in_tvalid || level_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    phase_t plan [10];
    phase_t p;
    int settings, r;
    plan = '{
      '{mdlr_pkg::MODE_DUTY,    4095, 0, 0, 0,     0,     0,  0,  40, 0},
      '{mdlr_pkg::MODE_DUTY,       1, 1, 1, 1,     0,  4095, 60, 100, 1},
      '{mdlr_pkg::MODE_CURRENT, 2048, 1, 0, 1, 16383, -4096, 60,  50, 0},
      '{mdlr_pkg::MODE_CURRENT, 4095, 0, 1, 0,   100,     0,  0,  50, 0},
      '{mdlr_pkg::MODE_SPEED,    300, 1, 1, 1,  8000,     0, 30,  50, 0},
      '{mdlr_pkg::MODE_SPEED,   4095, 0, 0, 1,     0,  4095, 60,  50, 0},
      '{ModeUnused,             1000, 1, 1, 1,     0,  4095, 10,  40, 0},
      '{mdlr_pkg::MODE_CURRENT,    0, 0, 0, 1,     0,  4095, 60,  20, 0},
      '{mdlr_pkg::MODE_SPEED,      0, 1, 1, 1,     0,     0,  5,  15, 0},
      '{mdlr_pkg::MODE_DUTY,       0, 0, 0, 0, 16383, -4096,  0,  20, 0}
    };
    settings = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // sensing off at reset: the level follows the target, saturated
    tick_q.push_back(tick_of(0, 0, 0, 0, 0, 0));
    tick_q.push_back(tick_of(16383, 4095, -4096, 16383, 360, 1));
    tick_q.push_back(tick_of(1000, 0, 4095, 0, 360, 0));
    tick_q.push_back(tick_of(999, 4095, 0, 16383, 0, 1));
    tick_q.push_back(tick_of(1001, 1, -1, 1, 1, 0));
    tick_q.push_back(tick_of(1, 0, 1, 8191, 255, 1));
    tick_q.push_back(tick_of(8192, 2048, -2048, 0, 256, 0));
    tick_q.push_back(tick_of(16383, 0, 0, 0, 0, 0));
    for (int k = 0; k < 17; k++) begin
      if (k < 10) begin
        p = plan[k];
      end else begin
        p.mode = ($urandom_range(0, 7) == 0) ? int'(ModeUnused) : int'($urandom_range(0, 2));
        r = $urandom_range(0, 5);
        p.lim = (r == 0) ? 0 : (r == 1) ? 4095 : int'($urandom_range(1, 4094));
        p.bbc = $urandom_range(0, 1);
        p.coast = $urandom_range(0, 1);
        p.wen = $urandom_range(0, 1);
        p.wspd = $urandom_range(0, 16383);
        p.wcur = -4096 + int'($urandom_range(0, 8191));
        p.wmax = $urandom_range(0, 60);
        p.count = 45;
        p.grow = (p.wcur > -4096 && $urandom_range(0, 2) == 0);
      end
      wait_drained();
      program_regs(p);
      settings++;
      repeat (p.count) tick_q.push_back(make_tick(p));
    end
    wait_drained();
    $display("Checked %0d results from %0d ticks under %0d register settings, %0d mismatches",
             results_seen, items_taken, settings, mismatches);
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
